// ===== rtl/i5gsmv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i5gsmv_pkg;

   // default sizing
   localparam int MAX_ROW_LENGTH_DEF = 4096;
   localparam int GROUP_SIZE_DEF     = 128;
   localparam int MAX_ROWS_DEF       = 4096;

   // field and accumulator widths
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int WCODE_W   = 5;
   localparam int ACT_W     = 16;
   localparam int SCALE_W   = 16;
   localparam int PROD_W    = WCODE_W + ACT_W;     // 21
   localparam int GSUM_W    = 28;
   localparam int SCALED_W  = GSUM_W + SCALE_W;    // 44
   localparam int RSUM_W    = 50;
   localparam int IDX_W     = 12;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT  = 1'd1;

   localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 13'd128;
   localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 13'd1;

   typedef struct packed {
      logic             capture;    // latch operands, form weight x activation
      logic             gsum_add;   // fold product into group sum
      logic             scale_mul;  // scale x group sum, clear group sum
      logic             row_add;    // fold scaled group into row sum
      logic             emit;       // load result register, clear row sum
      logic [IDX_W-1:0] row_index;
      logic             last_row;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/i5gsmv_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i5gsmv_dp (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire i5gsmv_pkg::dp_cmd_type                  cmd,
   output      i5gsmv_pkg::dp_status_type               status,
   input  wire logic        [i5gsmv_pkg::WCODE_W-1:0]   req_weight_code,
   input  wire logic signed [i5gsmv_pkg::ACT_W-1:0]     req_activation,
   input  wire logic signed [i5gsmv_pkg::SCALE_W-1:0]   req_group_scale,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   output      logic signed [i5gsmv_pkg::RSUM_W-1:0]    rsp_row_value,
   output      logic        [i5gsmv_pkg::IDX_W-1:0]     rsp_row_index,
   output      logic                                    rsp_last_row
);

   localparam int PROD_W   = i5gsmv_pkg::PROD_W;
   localparam int GSUM_W   = i5gsmv_pkg::GSUM_W;
   localparam int SCALED_W = i5gsmv_pkg::SCALED_W;
   localparam int RSUM_W   = i5gsmv_pkg::RSUM_W;
   localparam int SCALE_W  = i5gsmv_pkg::SCALE_W;
   localparam int IDX_W    = i5gsmv_pkg::IDX_W;

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SCALE_W-1:0]  scale_ff;
   logic signed [GSUM_W-1:0]   gsum_ff, gsum_in;
   logic signed [SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [RSUM_W-1:0]   rsum_ff, rsum_in;
   logic signed [RSUM_W-1:0]   out_value_ff;
   logic        [IDX_W-1:0]    out_index_ff;
   logic                       out_last_ff;
   logic                       out_valid_ff, out_valid_in;

   logic signed [PROD_W-1:0]   w_ext, a_ext;
   logic signed [GSUM_W:0]     gsum_wide;
   logic signed [RSUM_W:0]     rsum_wide;

   always_comb begin
      w_ext     = PROD_W'($signed(req_weight_code));
      a_ext     = PROD_W'(req_activation);
      prod_in   = w_ext * a_ext;
      scaled_in = SCALED_W'(gsum_ff) * SCALED_W'(scale_ff);
   end

   // saturating group accumulate
   always_comb begin
      gsum_wide = (GSUM_W+1)'(gsum_ff) + (GSUM_W+1)'(prod_ff);
      if (gsum_wide[GSUM_W] != gsum_wide[GSUM_W-1]) begin
         gsum_in = gsum_wide[GSUM_W] ? {1'b1, {(GSUM_W-1){1'b0}}}
                                     : {1'b0, {(GSUM_W-1){1'b1}}};
      end else begin
         gsum_in = gsum_wide[GSUM_W-1:0];
      end
   end

   // saturating row accumulate
   always_comb begin
      rsum_wide = (RSUM_W+1)'(rsum_ff) + (RSUM_W+1)'(scaled_ff);
      if (rsum_wide[RSUM_W] != rsum_wide[RSUM_W-1]) begin
         rsum_in = rsum_wide[RSUM_W] ? {1'b1, {(RSUM_W-1){1'b0}}}
                                     : {1'b0, {(RSUM_W-1){1'b1}}};
      end else begin
         rsum_in = rsum_wide[RSUM_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff  <= prod_in;
         scale_ff <= req_group_scale;
      end
      if (cmd.scale_mul) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.emit) begin
         out_value_ff <= rsum_ff;
         out_index_ff <= cmd.row_index;
         out_last_ff  <= cmd.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsum_ff      <= '0;
         rsum_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.gsum_add) begin
            gsum_ff <= gsum_in;
         end else if (cmd.scale_mul) begin
            gsum_ff <= '0;
         end
         if (cmd.row_add) begin
            rsum_ff <= rsum_in;
         end else if (cmd.emit) begin
            rsum_ff <= '0;
         end
      end
   end

   // a waiting beat leaves this cycle or none is held
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_value = out_value_ff;
   assign rsp_row_index = out_index_ff;
   assign rsp_last_row  = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/i5gsmv_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i5gsmv_ctrl #(
   parameter int MAX_ROW_LENGTH = i5gsmv_pkg::MAX_ROW_LENGTH_DEF,
   parameter int GROUP_SIZE     = i5gsmv_pkg::GROUP_SIZE_DEF,
   parameter int MAX_ROWS       = i5gsmv_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [i5gsmv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [i5gsmv_pkg::CFG_W-1:0]          csr_write_data,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   output      i5gsmv_pkg::dp_cmd_type                cmd,
   input  wire i5gsmv_pkg::dp_status_type             status
);

   localparam int CFG_W = i5gsmv_pkg::CFG_W;
   localparam int IDX_W = i5gsmv_pkg::IDX_W;
   localparam int COL_W = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
   localparam int GRP_W = $clog2(GROUP_SIZE);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GSUM  = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_ROW   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CFG_W-1:0] row_length_ff, row_count_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [GRP_W-1:0] gcol_ff, gcol_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             grp_end_ff, row_end_ff, last_ff;
   logic [IDX_W-1:0] idx_ff;

   logic [LEN_W-1:0] len_eff;
   logic [CNT_W-1:0] rows_eff;
   logic             accept, row_end, grp_end, last;

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(row_length_ff) > LEN_W'(MAX_ROW_LENGTH)) begin
         len_eff = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = LEN_W'(row_length_ff);
      end
      if (row_count_ff == '0) begin
         rows_eff = CNT_W'(1);
      end else if (CNT_W'(row_count_ff) > CNT_W'(MAX_ROWS)) begin
         rows_eff = CNT_W'(MAX_ROWS);
      end else begin
         rows_eff = CNT_W'(row_count_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign row_end   = (LEN_W'(col_ff) + LEN_W'(1)) >= len_eff;
   assign grp_end   = row_end || (gcol_ff == GRP_W'(GROUP_SIZE - 1));
   assign last      = (CNT_W'(row_ff) + CNT_W'(1)) >= rows_eff;

   always_comb begin
      col_in  = col_ff;
      gcol_in = gcol_ff;
      row_in  = row_ff;
      if (accept) begin
         col_in  = row_end ? '0 : col_ff + COL_W'(1);
         gcol_in = grp_end ? '0 : gcol_ff + GRP_W'(1);
         if (row_end) begin
            row_in = last ? '0 : row_ff + ROW_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_GSUM;
            end
         end
         S_GSUM: begin
            state_in = grp_end_ff ? S_SCALE : S_IDLE;
         end
         S_SCALE: begin
            state_in = S_ROW;
         end
         S_ROW: begin
            state_in = row_end_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture   = accept;
      cmd.gsum_add  = (state_ff == S_GSUM);
      cmd.scale_mul = (state_ff == S_SCALE);
      cmd.row_add   = (state_ff == S_ROW);
      cmd.emit      = (state_ff == S_EMIT) && status.out_free;
      cmd.row_index = idx_ff;
      cmd.last_row  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_end_ff <= grp_end;
         row_end_ff <= row_end;
         last_ff    <= last;
         idx_ff     <= IDX_W'(row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_length_ff <= i5gsmv_pkg::ROW_LENGTH_RST;
         row_count_ff  <= i5gsmv_pkg::ROW_COUNT_RST;
         col_ff        <= '0;
         gcol_ff       <= '0;
         row_ff        <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         gcol_ff  <= gcol_in;
         row_ff   <= row_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               i5gsmv_pkg::REG_ROW_LENGTH: row_length_ff <= csr_write_data;
               i5gsmv_pkg::REG_ROW_COUNT:  row_count_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/int5_group_scaled_matvec_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A finished row is loaded into the result register in the emit step, which waits while
//   an earlier result is untaken. A weight is taken only in idle, after the controller
//   steps the last through group add, then on a group end scale multiply and row add.
// The result register lets the next weight in while a finished row waits to be taken.
// Reset (synchronous, active high) clears positions, sums and the result valid,
//   and returns row_length to 128 and row_count to 1.
module int5_group_scaled_matvec_core #(
   parameter int MAX_ROW_LENGTH = i5gsmv_pkg::MAX_ROW_LENGTH_DEF,
   parameter int GROUP_SIZE     = i5gsmv_pkg::GROUP_SIZE_DEF,
   parameter int MAX_ROWS       = i5gsmv_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic        [i5gsmv_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [i5gsmv_pkg::CFG_W-1:0]    csr_write_data,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic        [i5gsmv_pkg::WCODE_W-1:0]  req_weight_code,
   input  wire logic signed [i5gsmv_pkg::ACT_W-1:0]    req_activation,
   input  wire logic signed [i5gsmv_pkg::SCALE_W-1:0]  req_group_scale,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic signed [i5gsmv_pkg::RSUM_W-1:0]   rsp_row_value,
   output      logic        [i5gsmv_pkg::IDX_W-1:0]    rsp_row_index,
   output      logic                                   rsp_last_row
);

   i5gsmv_pkg::dp_cmd_type    cmd;
   i5gsmv_pkg::dp_status_type status;

   i5gsmv_ctrl #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .GROUP_SIZE     (GROUP_SIZE),
      .MAX_ROWS       (MAX_ROWS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .cmd              (cmd),
      .status           (status)
   );

   i5gsmv_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_weight_code (req_weight_code),
      .req_activation  (req_activation),
      .req_group_scale (req_group_scale),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_value   (rsp_row_value),
      .rsp_row_index   (rsp_row_index),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
`default_nettype wire

// ===== rtl/i5gsmv_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i5gsmv_chk (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [i5gsmv_pkg::RSUM_W-1:0]   rsp_row_value,
   input wire logic        [i5gsmv_pkg::IDX_W-1:0]    rsp_row_index
);

   // one weight in flight: no beat straight after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   // a result only appears while the input side is busy
   a_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while input was open");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_value)
                                  && $stable(rsp_row_index))
      else $error("stalled result beat changed");

endmodule

bind int5_group_scaled_matvec_core i5gsmv_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_row_value (rsp_row_value),
   .rsp_row_index (rsp_row_index)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import i5gsmv_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_BEATS  = 1000;

   typedef struct packed {
      logic [RSUM_W-1:0] value;
      logic [IDX_W-1:0]  index;
      logic              last;
   } row_result_t;

   typedef enum logic [1:0] {OP_CSR, OP_BEAT, OP_RANDOM} stim_op_e;

   typedef struct {
      stim_op_e                 op;
      logic [CSR_IDX_W-1:0]     idx;
      logic [CFG_W-1:0]         data;    // register value, or beat count for OP_RANDOM
      logic [WCODE_W-1:0]       w;
      logic signed [ACT_W-1:0]  a;
      logic signed [SCALE_W-1:0] s;
      bit                       typed;
      logic [RSUM_W-1:0]        value;
      logic [IDX_W-1:0]         index;
      logic                     last;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [WCODE_W-1:0] req_weight_code = '0;
   logic signed [ACT_W-1:0] req_activation = '0;
   logic signed [SCALE_W-1:0] req_group_scale = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [RSUM_W-1:0] rsp_row_value;
   logic [IDX_W-1:0] rsp_row_index;
   logic rsp_last_row;

   // predictor state
   logic [CFG_W-1:0] length_reg;
   logic [CFG_W-1:0] count_reg;
   int               col_pos;
   int               row_pos;
   longint           group_acc;
   longint           row_acc;

   row_result_t pending_rows[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int unsigned clock_count = 0;
   int          stall_left = 0;
   bit          quiet_send = 1'b0;

   stim_row_t directed_rows [] = '{
      '{OP_RANDOM, REG_ROW_LENGTH, 13'd128, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_CSR, REG_ROW_LENGTH, 13'd1, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_CSR, REG_ROW_COUNT, 13'd3, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h10, 16'sh8000, 16'sh8000, 1'b1,
        -50'sd17179869184, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h0F, 16'sh7FFF, 16'sh7FFF, 1'b1,
        50'sd16105144335, 12'd1, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h1F, 16'sh1000, 16'sh1000, 1'b1,
        -50'sd16777216, 12'd2, 1'b1},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h00, 16'shFFFF, 16'shFFFF, 1'b1, 50'd0, 12'd0, 1'b0},
      // zero count acts as one, row position is kept
      '{OP_CSR, REG_ROW_COUNT, 13'd0, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h01, 16'sh0001, 16'sh0001, 1'b1, 50'sd1, 12'd1, 1'b1},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h01, 16'shFFFF, 16'sh0001, 1'b1, -50'sd1, 12'd0, 1'b1},
      '{OP_CSR, REG_ROW_LENGTH, 13'd0, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h02, 16'sh0003, 16'sh0004, 1'b1, 50'sd24, 12'd0, 1'b1},
      // scale only counts on the beat that closes the group
      '{OP_CSR, REG_ROW_LENGTH, 13'd2, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h03, 16'sh1000, 16'sh8000, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h1E, 16'sh0800, 16'sh1000, 1'b1,
        50'sd33554432, 12'd0, 1'b1},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h10, 16'sh7FFF, 16'sh8000, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h10, 16'sh8000, 16'sh7FFF, 1'b1,
        50'sd524272, 12'd0, 1'b1},
      // shrink length mid-row: next beat ends the row
      '{OP_CSR, REG_ROW_LENGTH, 13'd3, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_CSR, REG_ROW_COUNT, 13'd4, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h01, 16'sh1000, 16'sh0000, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_CSR, REG_ROW_LENGTH, 13'd1, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h01, 16'sh1000, 16'sh1000, 1'b1,
        50'sd33554432, 12'd0, 1'b0},
      // shrink count mid-matrix: next row is the last
      '{OP_CSR, REG_ROW_COUNT, 13'd1, 5'd0, 16'sd0, 16'sd0, 1'b0, 50'd0, 12'd0, 1'b0},
      '{OP_BEAT, REG_ROW_LENGTH, 13'd0, 5'h0F, 16'sh0000, 16'sh7FFF, 1'b1, 50'd0, 12'd1, 1'b1}
   };

   int5_group_scaled_matvec_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight_code  (req_weight_code),
      .req_activation   (req_activation),
      .req_group_scale  (req_group_scale),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_value    (rsp_row_value),
      .rsp_row_index    (rsp_row_index),
      .rsp_last_row     (rsp_last_row)
   );

   always #6 clock = ~clock;

   function automatic int bounded(input logic [CFG_W-1:0] r, input int maxv);
      if (r == '0) return 1;
      if (int'(r) > maxv) return maxv;
      return int'(r);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one weight into the dot product; returns 1 when it closes a row
   function automatic bit fold_weight(input logic [WCODE_W-1:0] w,
                                      input logic signed [ACT_W-1:0] a,
                                      input logic signed [SCALE_W-1:0] s,
                                      output row_result_t res);
      int len_e;
      int rows_e;
      bit row_end;
      bit group_end;
      bit last;
      len_e = bounded(length_reg, MAX_ROW_LENGTH_DEF);
      rows_e = bounded(count_reg, MAX_ROWS_DEF);
      row_end = (col_pos + 1 >= len_e);
      group_end = row_end || ((col_pos + 1) % GROUP_SIZE_DEF == 0);
      res = '0;
      group_acc = clamp(group_acc + longint'($signed(w)) * longint'(a),
                        -(64'sd1 <<< (GSUM_W - 1)), (64'sd1 <<< (GSUM_W - 1)) - 1);
      if (group_end) begin
         row_acc = clamp(row_acc + longint'(s) * group_acc,
                         -(64'sd1 <<< (RSUM_W - 1)), (64'sd1 <<< (RSUM_W - 1)) - 1);
         group_acc = 0;
      end
      if (!row_end) begin
         col_pos++;
         return 1'b0;
      end
      last = (row_pos + 1 >= rows_e);
      res.value = row_acc[RSUM_W-1:0];
      res.index = row_pos[IDX_W-1:0];
      res.last = last;
      row_acc = 0;
      col_pos = 0;
      row_pos = last ? 0 : row_pos + 1;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] random_q412();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_beat(input logic [WCODE_W-1:0] w, input logic signed [ACT_W-1:0] a,
                            input logic signed [SCALE_W-1:0] s, input bit typed,
                            input row_result_t typed_res);
      int gap;
      bit closes;
      row_result_t res;
      gap = quiet_send ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_weight_code <= w;
      req_activation <= a;
      req_group_scale <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      closes = fold_weight(w, a, s, res);
      if (typed) pending_rows.push_back(typed_res);
      else if (closes) pending_rows.push_back(res);
   endtask

   task automatic send_random_beat();
      send_beat(5'($urandom_range(0, 31)), random_q412(), random_q412(), 1'b0, '0);
   endtask

   // registers only change with the datapath drained
   task automatic write_settings(input bit do_len, input logic [CFG_W-1:0] len,
                                 input bit do_cnt, input logic [CFG_W-1:0] cnt);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (do_len) begin
         csr_write_enable <= 1'b1;
         csr_index <= REG_ROW_LENGTH;
         csr_write_data <= len;
         @(posedge clock);
         length_reg = len;
      end
      if (do_cnt) begin
         csr_write_enable <= 1'b1;
         csr_index <= REG_ROW_COUNT;
         csr_write_data <= cnt;
         @(posedge clock);
         count_reg = cnt;
      end
      csr_write_enable <= 1'b0;
   endtask

   // result side: random back-pressure, no new stall started while clock_count bit 9 is set
   always @(posedge clock) begin
      clock_count <= clock_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!clock_count[9] && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_rows
      row_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            $error("row result with none pending: row_index %0d, row_value %0d",
                   rsp_row_index, rsp_row_value);
            mismatches++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_row_value !== $signed(want.value)) begin
               $error("row_value: expected %0d, got %0d", $signed(want.value), rsp_row_value);
               mismatches++;
            end
            if (rsp_row_index !== want.index) begin
               $error("row_index: expected %0d, got %0d", want.index, rsp_row_index);
               mismatches++;
            end
            if (rsp_last_row !== want.last) begin
               $error("last_row: expected %0d, got %0d", want.last, rsp_last_row);
               mismatches++;
            end
         end
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      row_result_t typed_res;
      int random_beats;
      int len_e;
      int n;
      bit do_len;
      bit do_cnt;
      logic [CFG_W-1:0] len_val;
      logic [CFG_W-1:0] cnt_val;
      length_reg = ROW_LENGTH_RST;
      count_reg = ROW_COUNT_RST;
      col_pos = 0;
      row_pos = 0;
      group_acc = 0;
      row_acc = 0;
      random_beats = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].op)
            OP_CSR: begin
               if (directed_rows[i].idx == REG_ROW_LENGTH)
                  write_settings(1'b1, directed_rows[i].data, 1'b0, '0);
               else
                  write_settings(1'b0, '0, 1'b1, directed_rows[i].data);
            end
            OP_BEAT: begin
               typed_res.value = directed_rows[i].value;
               typed_res.index = directed_rows[i].index;
               typed_res.last = directed_rows[i].last;
               send_beat(directed_rows[i].w, directed_rows[i].a, directed_rows[i].s,
                         directed_rows[i].typed, typed_res);
            end
            default: repeat (directed_rows[i].data) send_random_beat();
         endcase
      end

      while (random_beats < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0: len_val = 13'd0;
            1: len_val = 13'd1;
            2: len_val = 13'd2;
            3: len_val = 13'($urandom_range(3, 20));
            4: len_val = 13'd127;
            5: len_val = 13'd128;
            6: len_val = 13'd129;
            7: len_val = 13'($urandom_range(130, 300));
            8: len_val = 13'd256;
            default: len_val = 13'($urandom_range(1, 64));
         endcase
         case ($urandom_range(0, 4))
            0: cnt_val = 13'd0;
            1: cnt_val = 13'd1;
            2: cnt_val = 13'd2;
            default: cnt_val = 13'($urandom_range(3, 6));
         endcase
         do_len = ($urandom_range(0, 3) != 2);
         do_cnt = ($urandom_range(0, 3) != 1);
         write_settings(do_len, len_val, do_cnt, cnt_val);
         quiet_send = ($urandom_range(0, 3) == 0);
         len_e = bounded(length_reg, MAX_ROW_LENGTH_DEF);
         n = len_e * $urandom_range(1, 3);
         // sometimes stop mid-row so the next settings land on a live row
         if ($urandom_range(0, 3) == 0) n += $urandom_range(0, len_e - 1);
         if (n > RANDOM_BEATS - random_beats) n = RANDOM_BEATS - random_beats;
         repeat (n) send_random_beat();
         random_beats += n;
      end

      // oversized length and count act as the maxima; the long row is then cut short
      quiet_send = 1'b0;
      write_settings(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
      repeat (40) send_random_beat();
      write_settings(1'b1, 13'd1, 1'b0, '0);
      repeat (40) send_random_beat();

      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/i5gsmv_pkg.sv
rtl/i5gsmv_dp.sv
rtl/i5gsmv_ctrl.sv
rtl/int5_group_scaled_matvec_core.sv
rtl/i5gsmv_chk.sv
tb/tb_top.sv
